// ===== sv/pcp_pkg.sv =====
`default_nettype none
package pcp_pkg;

  // default parameter values
  localparam int FRAC_BITS_DEF  = 16;
  localparam int PIXEL_BITS_DEF = 12;

  // world value width (32-bit fields, window widening, differences, spans)
  localparam int WORLD_BITS = 32;
  localparam int OW         = 36;
  // product and dividend width of the shared unit
  localparam int PW         = 2 * OW;
  localparam int CW         = $clog2(PW);

  // configuration register indexes
  localparam logic [2:0] REG_WIN_X_MIN = 3'd0;
  localparam logic [2:0] REG_WIN_X_MAX = 3'd1;
  localparam logic [2:0] REG_WIN_Y_MIN = 3'd2;
  localparam logic [2:0] REG_WIN_Y_MAX = 3'd3;
  localparam logic [2:0] REG_SCR_LEFT  = 3'd4;
  localparam logic [2:0] REG_SCR_RIGHT = 3'd5;
  localparam logic [2:0] REG_SCR_TOP   = 3'd6;
  localparam logic [2:0] REG_SCR_BOT   = 3'd7;

  typedef logic signed [OW-1:0] world_t;
  typedef logic signed [PW-1:0] wide_t;

  // shared multiply/divide unit phases
  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MUL  = 5'b00010,
    U_ADD  = 5'b00100,
    U_ABS  = 5'b01000,
    U_DIV  = 5'b10000
  } ustate_t;

  // request to the shared unit: trunc((a * b + k) / c), or a * b + k when no divide
  typedef struct packed {
    world_t a;
    world_t b;
    world_t c;
    logic   use_k;
    logic   div;
  } uop_t;

endpackage
`default_nettype wire

// ===== sv/polyline_clip_to_pixels.sv =====
`default_nettype none
// Polyline clipper and pixel mapper.
// Input channel (in_*): one curve point per item, x and y in signed Q16.16 world
// units; in_tuser marks the first point of a curve. Each later point closes a
// segment with the one before it. The segment is dropped when it lies wholly
// to one side of the plot window, otherwise clipped to the window and its
// ends mapped to screen pixels.
// Output channel (out_*): zero, one or two polyline vertices per input item;
// out_tuser marks a vertex that starts a new polyline, out_tlast the final
// vertex of an item.
// Configuration (cfg_*): window and screen edges, written while idle.
// All arithmetic runs on one shared serial multiply/divide unit. A plain
// multiply takes 36 steps, a multiply-divide 36 multiply steps and 72 divide
// steps. A segment uses up to 4 line divides, 4 pixel multiplies and 4 pixel
// divides; a curve start or a dropped segment uses none. in_tready is high
// only while the block is idle, so a new item is taken only after the last
// one's vertices have left. A stalled receiver holds the vertex on out_tdata
// and the block waits. Reset loads the default window and screen and forgets
// the previous point.
module polyline_clip_to_pixels #(
  parameter int FRAC_BITS  = pcp_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = pcp_pkg::PIXEL_BITS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  input  wire  [63:0]                            in_tdata,  // point_x, point_y
  input  wire                                    in_tuser,  // curve_start
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  output logic [((2*PIXEL_BITS+7)/8)*8-1:0]      out_tdata, // pixel_x, pixel_y, pad
  output logic                                   out_tuser, // begins_polyline
  output logic                                   out_tlast, // last_of_run
  input  wire                                    cfg_we,
  input  wire  [2:0]                             cfg_addr,
  input  wire  [31:0]                            cfg_wdata
);

  localparam int PB  = PIXEL_BITS;
  localparam int OW  = pcp_pkg::OW;
  localparam int PW  = pcp_pkg::PW;
  localparam int CW  = pcp_pkg::CW;
  localparam int WB  = pcp_pkg::WORLD_BITS;

  typedef enum logic [18:0] {
    S_IDLE  = 19'b1 << 0,
    S_CLASS = 19'b1 << 1,
    S_Y0    = 19'b1 << 2,
    S_Y1    = 19'b1 << 3,
    S_YCHK  = 19'b1 << 4,
    S_X0    = 19'b1 << 5,
    S_X1    = 19'b1 << 6,
    S_PSEL  = 19'b1 << 7,
    S_PX0A  = 19'b1 << 8,
    S_PX0B  = 19'b1 << 9,
    S_PY0A  = 19'b1 << 10,
    S_PY0B  = 19'b1 << 11,
    S_PX1A  = 19'b1 << 12,
    S_PX1B  = 19'b1 << 13,
    S_PY1A  = 19'b1 << 14,
    S_PY1B  = 19'b1 << 15,
    S_EMIT0 = 19'b1 << 16,
    S_EMIT1 = 19'b1 << 17,
    S_DONE  = 19'b1 << 18
  } state_t;

  function automatic pcp_pkg::world_t sx(input logic [WB-1:0] v);
    sx = {{(OW-WB){v[WB-1]}}, v};
  endfunction

  function automatic pcp_pkg::world_t zx(input logic [PB-1:0] v);
    zx = {{(OW-PB){1'b0}}, v};
  endfunction

  function automatic pcp_pkg::world_t clampw(input pcp_pkg::world_t v,
                                             input pcp_pkg::world_t lo,
                                             input pcp_pkg::world_t hi);
    priority if (v > hi) clampw = hi;
    else if (v < lo)     clampw = lo;
    else                 clampw = v;
  endfunction

  function automatic logic [PB-1:0] pclamp(input pcp_pkg::wide_t q,
                                           input logic [PB-1:0] hi,
                                           input logic [PB-1:0] lo);
    pcp_pkg::wide_t h;
    pcp_pkg::wide_t l;
    h = {{(PW-PB){1'b0}}, hi};
    l = {{(PW-PB){1'b0}}, lo};
    priority if (q > h) pclamp = hi;
    else if (q < l)     pclamp = lo;
    else                pclamp = q[PB-1:0];
  endfunction

  // configuration registers
  logic [WB-1:0] wxmin_r, wxmax_r, wymin_r, wymax_r;
  logic [PB-1:0] left_r, right_r, top_r, bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wxmin_r <= '0;
      wxmax_r <= WB'(655360);
      wymin_r <= '0;
      wymax_r <= WB'(655360);
      left_r  <= '0;
      right_r <= PB'(639);
      top_r   <= '0;
      bot_r   <= PB'(479);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pcp_pkg::REG_WIN_X_MIN: wxmin_r <= cfg_wdata;
        pcp_pkg::REG_WIN_X_MAX: wxmax_r <= cfg_wdata;
        pcp_pkg::REG_WIN_Y_MIN: wymin_r <= cfg_wdata;
        pcp_pkg::REG_WIN_Y_MAX: wymax_r <= cfg_wdata;
        pcp_pkg::REG_SCR_LEFT:  left_r  <= cfg_wdata[PB-1:0];
        pcp_pkg::REG_SCR_RIGHT: right_r <= cfg_wdata[PB-1:0];
        pcp_pkg::REG_SCR_TOP:   top_r   <= cfg_wdata[PB-1:0];
        pcp_pkg::REG_SCR_BOT:   bot_r   <= cfg_wdata[PB-1:0];
        default: ;
      endcase
    end
  end

  // ordered, widened window
  localparam pcp_pkg::world_t UNIT = OW'(1) << FRAC_BITS;
  pcp_pkg::world_t oxl, oxh, oyl, oyh;
  always_comb begin
    oxl = (sx(wxmin_r) <= sx(wxmax_r)) ? sx(wxmin_r) : sx(wxmax_r);
    oxh = (sx(wxmin_r) <= sx(wxmax_r)) ? sx(wxmax_r) : sx(wxmin_r);
    oyl = (sx(wymin_r) <= sx(wymax_r)) ? sx(wymin_r) : sx(wymax_r);
    oyh = (sx(wymin_r) <= sx(wymax_r)) ? sx(wymax_r) : sx(wymin_r);
    if (oxl == oxh) begin
      oxl = oxl - UNIT;
      oxh = oxh + UNIT;
    end
    if (oyl == oyh) begin
      oyl = oyl - UNIT;
      oyh = oyh + UNIT;
    end
  end

  // sequencer state
  state_t st_r;
  logic   issued_r;
  logic   have_prev_r, last_valid_r, start_emit_r, end_emit_r;
  pcp_pkg::world_t prevx_r, prevy_r, x0_r, y0_r, x1_r, y1_r;
  pcp_pkg::world_t xl_r, xh_r, yl_r, yh_r;
  pcp_pkg::world_t xx0_r, yy0_r, xx1_r, yy1_r, lastx_r, lasty_r;
  logic [PB-1:0] ix0_r, iy0_r, ix1_r, iy1_r, lpx_r, lpy_r;

  // shared unit interface
  pcp_pkg::uop_t   uop;
  logic            u_start, u_done_r;
  pcp_pkg::wide_t  res_r;
  pcp_pkg::ustate_t u_st_r;

  pcp_pkg::world_t dx, dy, spx, spy, dpx2, dpy2, bx2, by2;
  pcp_pkg::world_t q_ow;
  logic [PB-1:0]   pq_x, pq_y;
  logic            op_state, in_acc;

  assign dx   = x1_r - x0_r;
  assign dy   = y1_r - y0_r;
  assign spx  = xh_r - xl_r;
  assign spy  = yh_r - yl_r;
  assign dpx2 = (zx(right_r) - zx(left_r)) <<< 1;
  assign dpy2 = (zx(top_r) - zx(bot_r)) <<< 1;
  assign bx2  = (zx(left_r) <<< 1) + OW'(1);
  assign by2  = (zx(bot_r) <<< 1) + OW'(1);
  assign q_ow = res_r[OW-1:0];
  assign pq_x = pclamp(res_r, right_r, left_r);
  assign pq_y = pclamp(res_r, bot_r, top_r);

  assign op_state = (st_r == S_Y0) || (st_r == S_Y1) || (st_r == S_X0) ||
                    (st_r == S_X1) || (st_r == S_PX0A) || (st_r == S_PX0B) ||
                    (st_r == S_PY0A) || (st_r == S_PY0B) || (st_r == S_PX1A) ||
                    (st_r == S_PX1B) || (st_r == S_PY1A) || (st_r == S_PY1B);
  assign u_start  = op_state && !issued_r && (u_st_r == pcp_pkg::U_IDLE);
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // operand selection for the shared unit
  always_comb begin
    uop = '{a: '0, b: '0, c: '0, use_k: 1'b0, div: 1'b1};
    unique case (st_r)
      S_Y0:   uop = '{a: dy, b: xx0_r - x0_r, c: dx, use_k: 1'b0, div: 1'b1};
      S_Y1:   uop = '{a: dy, b: xx1_r - x1_r, c: dx, use_k: 1'b0, div: 1'b1};
      S_X0:   uop = '{a: yy0_r - y0_r, b: dx, c: dy, use_k: 1'b0, div: 1'b1};
      S_X1:   uop = '{a: yy1_r - y1_r, b: dx, c: dy, use_k: 1'b0, div: 1'b1};
      S_PX0A, S_PX1A: uop = '{a: spx, b: bx2, c: '0, use_k: 1'b0, div: 1'b0};
      S_PY0A, S_PY1A: uop = '{a: spy, b: by2, c: '0, use_k: 1'b0, div: 1'b0};
      S_PX0B: uop = '{a: xx0_r - xl_r, b: dpx2, c: spx <<< 1, use_k: 1'b1, div: 1'b1};
      S_PX1B: uop = '{a: xx1_r - xl_r, b: dpx2, c: spx <<< 1, use_k: 1'b1, div: 1'b1};
      S_PY0B: uop = '{a: yy0_r - yl_r, b: dpy2, c: spy <<< 1, use_k: 1'b1, div: 1'b1};
      S_PY1B: uop = '{a: yy1_r - yl_r, b: dpy2, c: spy <<< 1, use_k: 1'b1, div: 1'b1};
      default: ;
    endcase
  end

  // shared serial unit: sign-magnitude shift-add multiply, add k,
  // restoring divide one quotient bit per cycle
  pcp_pkg::wide_t  mcand_r, acc_r, k_r;
  logic [OW-1:0]   mplier_r, c_r, rem_r;
  logic            mneg_r, cneg_r, qneg_r, div_r;
  logic [CW-1:0]   cnt_r;
  pcp_pkg::wide_t  sum;
  logic [OW:0]     trial;
  logic            tge;

  assign sum   = mneg_r ? (k_r - acc_r) : (k_r + acc_r);
  assign trial = {rem_r, acc_r[PW-1]};
  assign tge   = trial >= {1'b0, c_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_st_r   <= pcp_pkg::U_IDLE;
      u_done_r <= 1'b0;
    end else begin
      u_done_r <= 1'b0;
      unique case (u_st_r)
        pcp_pkg::U_IDLE: begin
          if (u_start) begin
            mcand_r  <= {{(PW-OW){1'b0}}, (uop.a < 0) ? -uop.a : uop.a};
            mplier_r <= (uop.b < 0) ? -uop.b : uop.b;
            mneg_r   <= uop.a[OW-1] ^ uop.b[OW-1];
            c_r      <= (uop.c < 0) ? -uop.c : uop.c;
            cneg_r   <= uop.c[OW-1];
            k_r      <= uop.use_k ? res_r : '0;
            div_r    <= uop.div;
            acc_r    <= '0;
            cnt_r    <= '0;
            u_st_r   <= pcp_pkg::U_MUL;
          end
        end
        pcp_pkg::U_MUL: begin
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r + CW'(1);
          if (cnt_r == CW'(OW-1)) u_st_r <= pcp_pkg::U_ADD;
        end
        pcp_pkg::U_ADD: begin
          if (!div_r) begin
            res_r    <= sum;
            u_done_r <= 1'b1;
            u_st_r   <= pcp_pkg::U_IDLE;
          end else begin
            acc_r  <= sum;
            qneg_r <= sum[PW-1] ^ cneg_r;
            u_st_r <= pcp_pkg::U_ABS;
          end
        end
        pcp_pkg::U_ABS: begin
          acc_r  <= acc_r[PW-1] ? -acc_r : acc_r;
          rem_r  <= '0;
          cnt_r  <= '0;
          u_st_r <= pcp_pkg::U_DIV;
        end
        pcp_pkg::U_DIV: begin
          rem_r <= tge ? OW'(trial - {1'b0, c_r}) : trial[OW-1:0];
          acc_r <= {acc_r[PW-2:0], tge};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(PW-1)) begin
            // zero divisor gives zero
            if (c_r == '0) res_r <= '0;
            else if (qneg_r) res_r <= -{acc_r[PW-2:0], tge};
            else res_r <= {acc_r[PW-2:0], tge};
            u_done_r <= 1'b1;
            u_st_r   <= pcp_pkg::U_IDLE;
          end
        end
        default: u_st_r <= pcp_pkg::U_IDLE;
      endcase
    end
  end

  // segment classification
  logic drop, outside;
  always_comb begin
    drop = (x0_r < xl_r && x1_r < xl_r) || (x0_r > xh_r && x1_r > xh_r) ||
           (y0_r < yl_r && y1_r < yl_r) || (y0_r > yh_r && y1_r > yh_r);
    outside = x0_r < xl_r || x1_r < xl_r || x0_r > xh_r || x1_r > xh_r ||
              y0_r < yl_r || y1_r < yl_r || y0_r > yh_r || y1_r > yh_r;
  end

  logic [PB-1:0] iy1_new;
  assign iy1_new = pq_y;

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      issued_r     <= 1'b0;
      have_prev_r  <= 1'b0;
      last_valid_r <= 1'b0;
      start_emit_r <= 1'b0;
      end_emit_r   <= 1'b0;
      prevx_r      <= '0;
      prevy_r      <= '0;
      lastx_r      <= '0;
      lasty_r      <= '0;
      lpx_r        <= '0;
      lpy_r        <= '0;
    end else begin
      if (u_start) issued_r <= 1'b1;
      if (u_done_r) issued_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            prevx_r <= sx(in_tdata[31:0]);
            prevy_r <= sx(in_tdata[63:32]);
            if (in_tuser || !have_prev_r) begin
              have_prev_r  <= 1'b1;
              last_valid_r <= 1'b0;
              lpx_r        <= '0;
              lpy_r        <= '0;
              st_r         <= S_DONE;
            end else begin
              x0_r <= prevx_r;
              y0_r <= prevy_r;
              x1_r <= sx(in_tdata[31:0]);
              y1_r <= sx(in_tdata[63:32]);
              xl_r <= oxl;
              xh_r <= oxh;
              yl_r <= oyl;
              yh_r <= oyh;
              st_r <= S_CLASS;
            end
          end
        end
        S_CLASS: begin
          priority if (drop) begin
            st_r <= S_IDLE;
          end else if (!outside) begin
            xx0_r <= x0_r; yy0_r <= y0_r; xx1_r <= x1_r; yy1_r <= y1_r;
            st_r  <= S_PSEL;
          end else if (x0_r == x1_r) begin
            xx0_r <= x0_r; xx1_r <= x0_r;
            yy0_r <= clampw(y0_r, yl_r, yh_r);
            yy1_r <= clampw(y1_r, yl_r, yh_r);
            st_r  <= S_PSEL;
          end else begin
            xx0_r <= clampw(x0_r, xl_r, xh_r);
            xx1_r <= clampw(x1_r, xl_r, xh_r);
            st_r  <= S_Y0;
          end
        end
        S_Y0: if (u_done_r) begin
          yy0_r <= y0_r + q_ow;
          st_r  <= S_Y1;
        end
        S_Y1: if (u_done_r) begin
          yy1_r <= y1_r + q_ow;
          st_r  <= S_YCHK;
        end
        S_YCHK: begin
          // collapsed horizontal clip keeps the line values as they are
          if (yy0_r != yy1_r && dy != '0) begin
            yy0_r <= clampw(yy0_r, yl_r, yh_r);
            yy1_r <= clampw(yy1_r, yl_r, yh_r);
            st_r  <= S_X0;
          end else begin
            st_r <= S_PSEL;
          end
        end
        S_X0: if (u_done_r) begin
          xx0_r <= x0_r + q_ow;
          st_r  <= S_X1;
        end
        S_X1: if (u_done_r) begin
          xx1_r <= x1_r + q_ow;
          st_r  <= S_PSEL;
        end
        S_PSEL: begin
          if (last_valid_r && xx0_r == lastx_r && yy0_r == lasty_r) begin
            ix0_r        <= lpx_r;
            iy0_r        <= lpy_r;
            start_emit_r <= 1'b0;
            st_r         <= S_PX1A;
          end else begin
            start_emit_r <= 1'b1;
            st_r         <= S_PX0A;
          end
        end
        S_PX0A: if (u_done_r) st_r <= S_PX0B;
        S_PX0B: if (u_done_r) begin
          ix0_r <= pq_x;
          st_r  <= S_PY0A;
        end
        S_PY0A: if (u_done_r) st_r <= S_PY0B;
        S_PY0B: if (u_done_r) begin
          iy0_r <= pq_y;
          st_r  <= S_PX1A;
        end
        S_PX1A: if (u_done_r) st_r <= S_PX1B;
        S_PX1B: if (u_done_r) begin
          ix1_r <= pq_x;
          st_r  <= S_PY1A;
        end
        S_PY1A: if (u_done_r) st_r <= S_PY1B;
        S_PY1B: if (u_done_r) begin
          iy1_r        <= iy1_new;
          lastx_r      <= xx1_r;
          lasty_r      <= yy1_r;
          last_valid_r <= 1'b1;
          lpx_r        <= ix1_r;
          lpy_r        <= iy1_new;
          end_emit_r   <= (ix0_r != ix1_r) || (iy0_r != iy1_new);
          priority if (start_emit_r) st_r <= S_EMIT0;
          else if ((ix0_r != ix1_r) || (iy0_r != iy1_new)) st_r <= S_EMIT1;
          else st_r <= S_IDLE;
        end
        S_EMIT0: if (out_tready) st_r <= end_emit_r ? S_EMIT1 : S_IDLE;
        S_EMIT1: if (out_tready) st_r <= S_IDLE;
        S_DONE:  st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // output vertex from registers
  always_comb begin
    out_tvalid = (st_r == S_EMIT0) || (st_r == S_EMIT1);
    out_tdata  = '0;
    if (st_r == S_EMIT1) out_tdata[2*PB-1:0] = {iy1_r, ix1_r};
    else                 out_tdata[2*PB-1:0] = {iy0_r, ix0_r};
    out_tuser  = (st_r == S_EMIT0);
    out_tlast  = (st_r == S_EMIT1) || !end_emit_r;
  end

  // checks
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while a vertex waits");
  a_done_op: assert property (@(posedge clk) disable iff (!rst_n)
    u_done_r |-> op_state) else $error("unit result outside an operation");
  a_start_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> out_tuser)
    else $error("non-final vertex is not a polyline start");
  a_new_curve: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (have_prev_r && !last_valid_r))
    else $error("curve start did not reset the polyline");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic        begins;
    logic        last;
  } vertex_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        start;
    bit          typed;
    int          n;
    vertex_t     v0;
    vertex_t     v1;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  polyline_clip_to_pixels DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // point_x, point_y
    .in_tuser(in_tuser),   // curve_start
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), // pixel_x, pixel_y
    .out_tuser(out_tuser), // begins_polyline
    .out_tlast(out_tlast), // last_of_run
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // predictor copy of registers and curve state
  longint win_xa = 0, win_xb = 655360, win_ya = 0, win_yb = 655360;
  longint scr_l = 0, scr_r = 639, scr_t = 0, scr_b = 479;
  longint prev_x = 0, prev_y = 0;
  bit     have_prev = 0;
  longint end_x = 0, end_y = 0;
  bit     end_valid = 0;
  longint end_px = 0, end_py = 0;

  vertex_t expected_vertices[$];
  int      mismatches = 0;
  int      vertices_seen = 0;
  int      points_sent = 0;
  int      segments_drawn = 0;
  bit      rx_no_stall = 0;
  bit      tx_no_gap = 0;
  row_t    rows[$];

  // trunc(a * b / c) with a 128-bit product
  function automatic longint line_muldiv(longint a, longint b, longint c);
    bit neg;
    logic [63:0] ua, ub, uc;
    logic [127:0] p;
    logic [127:0] q;
    neg = 0;
    if (a < 0) begin neg = ~neg; ua = -a; end else ua = a;
    if (b < 0) begin neg = ~neg; ub = -b; end else ub = b;
    if (c < 0) begin neg = ~neg; uc = -c; end else uc = c;
    if (uc == 0) return 0;
    p = ua;
    p = p * ub;
    q = p / uc;
    q = q & 128'h3FFFFFFFFFFFFFFF;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clamp_w(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // scale/offset, +1/2 truncated, then clamp to [lo_edge, hi_edge]
  function automatic longint map_pixel(longint v, longint lo, longint span, longint base,
                                       longint dpix, longint hi_edge, longint lo_edge);
    longint num, r;
    num = 2 * base * span + 2 * (v - lo) * dpix + span;
    r = num / (2 * span);
    if (r > hi_edge) r = hi_edge;
    else if (r < lo_edge) r = lo_edge;
    return r;
  endfunction

  function automatic void order_edges(longint a, longint b, output longint lo,
                                      output longint hi);
    if (a <= b) begin lo = a; hi = b; end else begin lo = b; hi = a; end
    if (lo == hi) begin
      lo = lo - (longint'(1) << 16);
      hi = hi + (longint'(1) << 16);
    end
  endfunction

  // clip one segment and produce up to two polyline vertices
  function automatic int predict_vertices(logic [31:0] px32, logic [31:0] py32,
                                          logic start, output vertex_t v[2]);
    longint x1, y1, x0, y0, xl, xh, yl, yh, xx0, xx1, yy0, yy1;
    longint ix0, iy0, ix1, iy1, dx, dy, y00, y11;
    int n;
    n = 0;
    v[0] = '0;
    v[1] = '0;
    x1 = longint'(signed'(px32));
    y1 = longint'(signed'(py32));
    if (start || !have_prev) begin
      prev_x = x1; prev_y = y1; have_prev = 1;
      end_valid = 0; end_px = 0; end_py = 0;
      return 0;
    end
    x0 = prev_x; y0 = prev_y;
    prev_x = x1; prev_y = y1;
    order_edges(win_xa, win_xb, xl, xh);
    order_edges(win_ya, win_yb, yl, yh);
    if ((x0 < xl && x1 < xl) || (x0 > xh && x1 > xh)) return 0;
    if ((y0 < yl && y1 < yl) || (y0 > yh && y1 > yh)) return 0;
    if (x0 < xl || x1 < xl || x0 > xh || x1 > xh ||
        y0 < yl || y1 < yl || y0 > yh || y1 > yh) begin
      if (x0 != x1) begin
        dx = x1 - x0; dy = y1 - y0;
        xx0 = clamp_w(x0, xl, xh);
        xx1 = clamp_w(x1, xl, xh);
        y00 = y0 + line_muldiv(dy, xx0 - x0, dx);
        y11 = y1 + line_muldiv(dy, xx1 - x1, dx);
        if (y00 != y11 && dy != 0) begin
          yy0 = clamp_w(y00, yl, yh);
          yy1 = clamp_w(y11, yl, yh);
          xx0 = x0 + line_muldiv(yy0 - y0, dx, dy);
          xx1 = x1 + line_muldiv(yy1 - y1, dx, dy);
        end else begin
          yy0 = y00; yy1 = y11;
        end
      end else begin
        xx0 = x0; xx1 = x0;
        yy0 = clamp_w(y0, yl, yh);
        yy1 = clamp_w(y1, yl, yh);
      end
    end else begin
      xx0 = x0; yy0 = y0; xx1 = x1; yy1 = y1;
    end
    segments_drawn++;
    // continue from the stored pixel when the start matches the last end
    if (end_valid && xx0 == end_x && yy0 == end_y) begin
      ix0 = end_px; iy0 = end_py;
    end else begin
      ix0 = map_pixel(xx0, xl, xh - xl, scr_l, scr_r - scr_l, scr_r, scr_l);
      iy0 = map_pixel(yy0, yl, yh - yl, scr_b, scr_t - scr_b, scr_b, scr_t);
      v[n] = '{px: ix0[11:0], py: iy0[11:0], begins: 1'b1, last: 1'b0};
      n++;
    end
    end_x = xx1; end_y = yy1; end_valid = 1;
    ix1 = map_pixel(xx1, xl, xh - xl, scr_l, scr_r - scr_l, scr_r, scr_l);
    iy1 = map_pixel(yy1, yl, yh - yl, scr_b, scr_t - scr_b, scr_b, scr_t);
    end_px = ix1; end_py = iy1;
    if (ix0 != ix1 || iy0 != iy1) begin
      v[n] = '{px: ix1[11:0], py: iy1[11:0], begins: 1'b0, last: 1'b0};
      n++;
    end
    if (n > 0) v[n-1].last = 1'b1;
    return n;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      pcp_pkg::REG_WIN_X_MIN: win_xa = longint'(signed'(val));
      pcp_pkg::REG_WIN_X_MAX: win_xb = longint'(signed'(val));
      pcp_pkg::REG_WIN_Y_MIN: win_ya = longint'(signed'(val));
      pcp_pkg::REG_WIN_Y_MAX: win_yb = longint'(signed'(val));
      pcp_pkg::REG_SCR_LEFT:  scr_l = val[11:0];
      pcp_pkg::REG_SCR_RIGHT: scr_r = val[11:0];
      pcp_pkg::REG_SCR_TOP:   scr_t = val[11:0];
      pcp_pkg::REG_SCR_BOT:   scr_b = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_view(int xa, int xb, int ya, int yb, int l, int r, int t, int b);
    write_reg(pcp_pkg::REG_WIN_X_MIN, xa);
    write_reg(pcp_pkg::REG_WIN_X_MAX, xb);
    write_reg(pcp_pkg::REG_WIN_Y_MIN, ya);
    write_reg(pcp_pkg::REG_WIN_Y_MAX, yb);
    write_reg(pcp_pkg::REG_SCR_LEFT, l);
    write_reg(pcp_pkg::REG_SCR_RIGHT, r);
    write_reg(pcp_pkg::REG_SCR_TOP, t);
    write_reg(pcp_pkg::REG_SCR_BOT, b);
  endtask

  // wait for all vertices, then let any resultless item finish
  task automatic drain();
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  // present one point and predict at acceptance
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic start, bit typed,
                            int tn, vertex_t t0, vertex_t t1);
    int gap, n;
    vertex_t v[2];
    gap = tx_no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    in_tuser <= start;
    do @(posedge clk); while (!in_tready);
    n = predict_vertices(x, y, start, v);
    if (typed) begin
      n = tn; v[0] = t0; v[1] = t1;
    end
    for (int i = 0; i < n; i++) expected_vertices.push_back(v[i]);
    points_sent++;
  endtask

  task automatic end_of_stream();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic add_row(logic [31:0] x, logic [31:0] y, logic start, bit typed = 0,
                         int n = 0, vertex_t v0 = '0, vertex_t v1 = '0);
    row_t r;
    r.x = x; r.y = y; r.start = start; r.typed = typed; r.n = n; r.v0 = v0; r.v1 = v1;
    rows.push_back(r);
  endtask

  // pick a coordinate around the current window, now and then anywhere
  function automatic logic [31:0] pick_coord(longint a, longint b);
    longint lo, hi, span, v;
    order_edges(a, b, lo, hi);
    if ($urandom_range(0, 6) == 0) return $urandom;
    span = hi - lo;
    v = lo - span / 4 + (span * 3 / 2 / 1024) * $urandom_range(0, 1024)
        + $urandom_range(0, 3) - 1;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic random_points(int count);
    logic [31:0] x, y, lx, ly;
    int k;
    lx = 0; ly = 0;
    for (int i = 0; i < count; i++) begin
      x = pick_coord(win_xa, win_xb);
      y = pick_coord(win_ya, win_yb);
      k = $urandom_range(0, 9);
      if (k == 0) x = lx;
      else if (k == 1) y = ly;
      send_point(x, y, $urandom_range(0, 7) == 0, 0, 0, '0, '0);
      lx = x; ly = y;
      // sender holds off once until the block has caught up
      if (i == count / 2) begin
        end_of_stream();
        while (expected_vertices.size() != 0) @(posedge clk);
      end
    end
    end_of_stream();
  endtask

  // result check
  always @(posedge clk) begin
    vertex_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{px: out_tdata[11:0], py: out_tdata[23:12], begins: out_tuser,
              last: out_tlast};
      vertices_seen++;
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex px=%0d py=%0d begins=%0b last=%0b",
                   got.px, got.py, got.begins, got.last);
      end else begin
        want = expected_vertices.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: exp px=%0d py=%0d begins=%0b last=%0b, got px=%0d py=%0d begins=%0b last=%0b",
                     want.px, want.py, want.begins, want.last,
                     got.px, got.py, got.begins, got.last);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int stall;
    forever begin
      stall = rx_no_stall ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset window: 0..10.0 world to 640x480 screen
    add_row(32'd0, 32'd0, 1'b0, 1, 0);                 // no previous point
    add_row(32'd655360, 32'd655360, 1'b0, 1, 2,
            '{12'd0, 12'd479, 1'b1, 1'b0}, '{12'd639, 12'd0, 1'b0, 1'b1});
    add_row(32'h80000000, 32'h80000000, 1'b1, 1, 0);   // new curve
    add_row(32'h80000000, 32'h7FFFFFFF, 1'b0, 1, 0);   // dropped, left of window
    add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    add_row(32'h7FFFFFFF, 32'h80000000, 1'b0);         // vertical, dropped right of window
    add_row(32'hFFFF0000, 32'd327680, 1'b1, 1, 0);
    add_row(32'd983040, 32'd327680, 1'b0);             // horizontal, both ends out
    add_row(32'd327680, 32'd983040, 1'b0);
    add_row(32'd327680, 32'hFFFF0000, 1'b0);           // vertical crossing the window top and bottom
    add_row(32'd100000, 32'd100000, 1'b0);
    add_row(32'd200000, 32'd600000, 1'b0);             // continues the polyline
    add_row(32'd200001, 32'd600001, 1'b0);             // same pixel, no new vertex
    add_row(32'h80000000, 32'h7FFFFFFF, 1'b0);
    add_row(32'h7FFFFFFF, 32'h80000000, 1'b0);         // long diagonal
    add_row(32'h00000000, 32'hFFFFFFFF, 1'b1, 1, 0);
    add_row(32'hFFFFFFFF, 32'h00000000, 1'b0);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].start, rows[i].typed,
                                 rows[i].n, rows[i].v0, rows[i].v1);
    end_of_stream();
    random_points(120);
    drain();

    // full range window, full screen
    rx_no_stall = 1; tx_no_gap = 1;
    set_view(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 4095, 0, 4095);
    random_points(150);
    drain();

    // reversed window and screen, narrow screen extremes
    rx_no_stall = 0; tx_no_gap = 0;
    set_view(32'd100000, -32'd50000, 32'd70000, -32'd900000, 4095, 4000, 4095, 3);
    random_points(150);
    drain();

    // zero-width window in x and y
    set_view(32'd65536, 32'd65536, -32'd12345, -32'd12345, 10, 20, 30, 40);
    random_points(140);
    drain();

    // ordinary window near the positive x and negative y extremes
    set_view(32'h7FF00000, 32'h7FFFFFFF, 32'h80000000, 32'h80100000, 100, 1379, 50, 1050);
    random_points(150);
    drain();

    // window of zero width in x at the negative extreme, single-pixel screen
    set_view(32'h80000000, 32'h80000000, 32'd0, 32'd1, 7, 7, 0, 0);
    random_points(130);
    drain();

    $display("Sent %0d points over six window/screen settings: %0d segments drawn, %0d vertices checked.",
             points_sent, segments_drawn, vertices_seen);
    $display("Covered reversed, zero-width and full-range windows and screen extremes.");
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d vertices missing", mismatches,
               expected_vertices.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
